// File: design/assert_macros.svh
// Assertion macros used by the top level of the RMSprop step scaler.
// Each macro samples on clk and is held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: the consequent is checked at the same clock edge as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next clock edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rss_pkg.sv
// Package of the RMSprop step scaler: field widths, register codes and reset values.
// Used by the channel interfaces, the root unit and the top level.
package rss_pkg;

    localparam int GRAD_W  = 16;
    localparam int SLOT_W  = 10;
    localparam int DIR_W   = 24;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int ACC_W   = 32;
    localparam int RAD_W   = 33;
    localparam int ROOT_W  = 25;

    typedef enum logic [CIDX_W-1:0] {
        CFG_DECAY     = 2'd0,
        CFG_EPSILON   = 2'd1,
        CFG_STEP_GAIN = 2'd2
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] DECAY_RST     = 16'd58982;
    localparam logic [CFG_W-1:0] EPSILON_RST   = 16'd17;
    localparam logic [CFG_W-1:0] STEP_GAIN_RST = 16'd256;

    localparam logic [DIR_W-1:0] DIR_POS_MAX = 24'h7FFFFF;
    localparam logic [DIR_W-1:0] DIR_NEG_MAX = 24'h800000;

endpackage

// File: design/rss_if.sv
// Valid/ready channel interfaces of the RMSprop step scaler.
// Depends on rss_pkg for the field widths.
interface rss_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [rss_pkg::GRAD_W-1:0]  grad;
    logic        [rss_pkg::SLOT_W-1:0]  slot;

    modport source (output valid, output grad, output slot, input ready);
    modport sink (input valid, input grad, input slot, output ready);
endinterface

interface rss_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [rss_pkg::DIR_W-1:0]   direction;
    logic                               clipped;

    modport source (output valid, output direction, output clipped, input ready);
    modport sink (input valid, input direction, input clipped, output ready);
endinterface

// File: design/rss_sqrt.sv
// Digit-recurrence square root: floor(sqrt(radicand * 65536)), two radicand bits a cycle.
// Depends on rss_pkg for the operand widths.
module rss_sqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [rss_pkg::RAD_W-1:0]    radicand,
    output logic                         done,
    output logic [rss_pkg::ROOT_W-1:0]   root
);

    localparam int VW = 2 * rss_pkg::ROOT_W;
    localparam int RW = rss_pkg::ROOT_W + 2;

    logic [VW-1:0]                 v_reg, v_next;
    logic [RW-1:0]                 rem_reg, rem_next;
    logic [rss_pkg::ROOT_W-1:0]    root_reg, root_next;
    logic [4:0]                    cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [RW+1:0]                 trem;
    logic [RW+1:0]                 trial;
    logic                          ge;

    always_comb
    begin
        trem  = {rem_reg, v_reg[VW-1:VW-2]};
        trial = {2'b00, root_reg, 2'b01};
        ge    = (trem >= trial);

        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            v_next    = {1'b0, radicand, 16'd0};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            v_next    = {v_reg[VW-3:0], 2'b00};
            rem_next  = ge ? RW'(trem - trial) : RW'(trem);
            root_next = {root_reg[rss_pkg::ROOT_W-2:0], ge};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'(rss_pkg::ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: design/rmsprop_step_scaler_top.sv
// Top level of the RMSprop step scaler: sequencer, shift-add multipliers, divider, slot store.
// Depends on rss_pkg, rss_in_if, rss_out_if, rss_sqrt and assert_macros.svh.
//
// Each request passes through bit-serial squaring and gain product, bit-serial decay blend,
// the square-root recurrence, restoring division and the control states between them; the
// next request is taken once the result register is free to load the result. One request is
// in work at a time, since the next one may use the same slot. After reset the slot store is
// swept to zero, one entry per cycle, during which no request is taken; configuration writes
// are taken at any time.
`include "assert_macros.svh"

module rmsprop_step_scaler_top
#(
    parameter int DEPTH = 1024
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    rss_in_if.sink                         req,
    rss_out_if.source                      result,
    input  logic                           cfg_we,
    input  logic [rss_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [rss_pkg::CFG_W-1:0]      cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = rss_pkg::SLOT_W;
    localparam int KW = 26;
    localparam logic [KW-1:0] DK_INIT = KW'(DEPTH) << (SW - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_MUL1  = 10'b0000000100,
        ST_PREP  = 10'b0000001000,
        ST_MUL2  = 10'b0000010000,
        ST_SUM   = 10'b0000100000,
        ST_ROOT  = 10'b0001000000,
        ST_DCHK  = 10'b0010000000,
        ST_DIV   = 10'b0100000000,
        ST_FIN   = 10'b1000000000
    } state_t;

    state_t                         state_reg, state_next;
    logic [4:0]                     cnt_reg, cnt_next;
    logic [AW-1:0]                  clr_reg, clr_next;

    logic [rss_pkg::CFG_W-1:0]      decay_reg, eps_reg, gain_reg;

    logic                           neg_reg, neg_next;
    logic [15:0]                    mq_reg, mq_next;
    logic [31:0]                    mg_reg, mg_next;
    logic [31:0]                    mn_reg, mn_next;
    logic [31:0]                    g2_reg, g2_next;
    logic [31:0]                    ng_reg, ng_next;
    logic [SW-1:0]                  slot_rem_reg, slot_rem_next;
    logic [KW-1:0]                  dk_reg, dk_next;

    logic signed [49:0]             d_reg, d_next;
    logic signed [49:0]             acc_reg, acc_next;
    logic [15:0]                    dq_reg, dq_next;

    logic                           zero_reg, zero_next;
    logic                           clip_acc_reg, clip_acc_next;
    logic                           big_reg, big_next;
    logic [25:0]                    rem_reg, rem_next;
    logic [23:0]                    nsh_reg, nsh_next;
    logic [23:0]                    q_reg, q_next;

    logic                           out_valid_reg, out_valid_next;
    logic [rss_pkg::DIR_W-1:0]      dir_reg, dir_next;
    logic                           clip_reg, clip_next;

    logic [rss_pkg::ACC_W-1:0]      mem [DEPTH];
    logic [rss_pkg::ACC_W-1:0]      rd_reg;
    logic                           mem_we, mem_re;
    logic [AW-1:0]                  mem_wa, mem_ra;
    logic [rss_pkg::ACC_W-1:0]      mem_wd;

    logic                           accept;
    logic [15:0]                    gbits, mag;
    logic [rss_pkg::ACC_W-1:0]      acc_sat;
    logic [rss_pkg::RAD_W-1:0]      rad;
    logic                           root_start, root_done;
    logic [rss_pkg::ROOT_W-1:0]     root;
    logic [25:0]                    tdiv;
    logic                           qbit;
    logic                           cap;
    logic [rss_pkg::DIR_W-1:0]      dir_fin;
    logic                           load_out;

    rss_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (rad),
        .done     (root_done),
        .root     (root)
    );

    assign accept     = req.valid && req.ready;
    assign req.ready  = (state_reg == ST_IDLE);
    assign gbits      = req.grad;
    assign mag        = gbits[15] ? (16'd0 - gbits) : gbits;
    assign acc_sat    = acc_reg[48] ? '1 : acc_reg[47:16];
    assign rad        = {1'b0, acc_sat} + {17'd0, eps_reg};
    assign root_start = (state_reg == ST_SUM);
    assign tdiv       = {rem_reg[24:0], nsh_reg[23]};
    assign qbit       = (tdiv >= {1'b0, root});

    always_comb
    begin
        if (neg_reg)
        begin
            cap     = big_reg || (q_reg > rss_pkg::DIR_NEG_MAX);
            dir_fin = cap ? rss_pkg::DIR_NEG_MAX : (24'd0 - q_reg);
        end
        else
        begin
            cap     = big_reg || (q_reg > rss_pkg::DIR_POS_MAX);
            dir_fin = cap ? rss_pkg::DIR_POS_MAX : q_reg;
        end
        if (zero_reg)
        begin
            cap     = 1'b0;
            dir_fin = '0;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        clr_next      = clr_reg;
        neg_next      = neg_reg;
        mq_next       = mq_reg;
        mg_next       = mg_reg;
        mn_next       = mn_reg;
        g2_next       = g2_reg;
        ng_next       = ng_reg;
        slot_rem_next = slot_rem_reg;
        dk_next       = dk_reg;
        d_next        = d_reg;
        acc_next      = acc_reg;
        dq_next       = dq_reg;
        zero_next     = zero_reg;
        clip_acc_next = clip_acc_reg;
        big_next      = big_reg;
        rem_next      = rem_reg;
        nsh_next      = nsh_reg;
        q_next        = q_reg;
        mem_we        = 1'b0;
        mem_wa        = clr_reg;
        mem_wd        = '0;
        mem_re        = 1'b0;
        mem_ra        = AW'(slot_rem_reg);
        load_out      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next      = gbits[15];
                    mq_next       = mag;
                    mg_next       = {16'd0, mag};
                    mn_next       = {16'd0, gain_reg};
                    g2_next       = '0;
                    ng_next       = '0;
                    slot_rem_next = req.slot;
                    dk_next       = DK_INIT;
                    cnt_next      = '0;
                    state_next    = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                if (mq_reg[0])
                begin
                    g2_next = g2_reg + mg_reg;
                    ng_next = ng_reg + mn_reg;
                end
                mq_next = {1'b0, mq_reg[15:1]};
                mg_next = {mg_reg[30:0], 1'b0};
                mn_next = {mn_reg[30:0], 1'b0};
                if ((cnt_reg < 5'(SW)) &&
                    ({{(KW-SW){1'b0}}, slot_rem_reg} >= dk_reg))
                begin
                    slot_rem_next = SW'({{(KW-SW){1'b0}}, slot_rem_reg} - dk_reg);
                end
                dk_next  = {1'b0, dk_reg[KW-1:1]};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    mem_re     = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                d_next     = $signed({18'd0, rd_reg}) - $signed({18'd0, g2_reg});
                acc_next   = $signed({2'b00, g2_reg, 16'd0});
                dq_next    = decay_reg;
                cnt_next   = '0;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                if (dq_reg[0])
                begin
                    acc_next = acc_reg + d_reg;
                end
                d_next   = d_reg <<< 1;
                dq_next  = {1'b0, dq_reg[15:1]};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                mem_we        = 1'b1;
                mem_wa        = AW'(slot_rem_reg);
                mem_wd        = acc_sat;
                clip_acc_next = acc_reg[48];
                zero_next     = (rad == '0);
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = ST_DCHK;
                end
            end
            ST_DCHK:
            begin
                big_next   = ({5'd0, ng_reg} >= {root, 12'd0});
                rem_next   = {6'd0, ng_reg[31:12]};
                nsh_next   = {ng_reg[11:0], 12'd0};
                q_next     = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = qbit ? (tdiv - {1'b0, root}) : tdiv;
                nsh_next = {nsh_reg[22:0], 1'b0};
                q_next   = {q_reg[22:0], qbit};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd23)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        dir_next       = dir_reg;
        clip_next      = clip_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            dir_next       = dir_fin;
            clip_next      = clip_acc_reg | cap;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            decay_reg     <= rss_pkg::DECAY_RST;
            eps_reg       <= rss_pkg::EPSILON_RST;
            gain_reg      <= rss_pkg::STEP_GAIN_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rss_pkg::CFG_DECAY:     decay_reg <= cfg_data;
                    rss_pkg::CFG_EPSILON:   eps_reg   <= cfg_data;
                    rss_pkg::CFG_STEP_GAIN: gain_reg  <= cfg_data;
                    default:                ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        mq_reg       <= mq_next;
        mg_reg       <= mg_next;
        mn_reg       <= mn_next;
        g2_reg       <= g2_next;
        ng_reg       <= ng_next;
        slot_rem_reg <= slot_rem_next;
        dk_reg       <= dk_next;
        d_reg        <= d_next;
        acc_reg      <= acc_next;
        dq_reg       <= dq_next;
        zero_reg     <= zero_next;
        clip_acc_reg <= clip_acc_next;
        big_reg      <= big_next;
        rem_reg      <= rem_next;
        nsh_reg      <= nsh_next;
        q_reg        <= q_next;
        dir_reg      <= dir_next;
        clip_reg     <= clip_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_ra];
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.direction = dir_reg;
    assign result.clipped   = clip_reg;

    `ASSERT_NEXT(a_accept_starts_work, accept, state_reg == ST_MUL1, "request did not start work")
    `ASSERT_SAME(a_root_done_in_root, root_done, state_reg == ST_ROOT, "root done outside wait")
    `ASSERT_SAME(a_slot_ok, state_reg == ST_SUM, int'(slot_rem_reg) < DEPTH, "slot not reduced")
    `ASSERT_NEXT(a_load_sets_valid, load_out, result.valid, "result not presented")

endmodule

// File: bench/rmsprop_step_scaler_top_tb.sv
// Self-checking bench for rmsprop_step_scaler_top: directed and random gradient requests, a bit-true
// predictor of the per-slot mean square and the scaled step, and checks per result field.
// Depends on rss_pkg, the rss_in_if and rss_out_if interfaces and the RTL top level.
module rmsprop_step_scaler_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS            = 1024;
    localparam int PHASES           = 8;
    localparam int RANDOM_PER_PHASE = 155;
    localparam int HOLD_AT          = 90;
    localparam int HOLD_CYCLES      = 600;
    localparam int SETTLE_CYCLES    = 10;
    localparam int TAIL_CYCLES      = 200;
    localparam int WATCHDOG_CYCLES  = 6000;

    localparam logic [rss_pkg::CIDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [rss_pkg::GRAD_W-1:0] GRAD_MAX  = 16'h7FFF;
    localparam logic [rss_pkg::GRAD_W-1:0] GRAD_MIN  = 16'h8000;
    localparam logic [rss_pkg::GRAD_W-1:0] GRAD_NEG1 = 16'hFFFF;

    typedef struct packed {
        logic signed [rss_pkg::GRAD_W-1:0] grad;
        logic        [rss_pkg::SLOT_W-1:0] slot;
    } grad_req_t;

    typedef struct packed {
        logic signed [rss_pkg::DIR_W-1:0] direction;
        logic                             clipped;
    } step_res_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [rss_pkg::CIDX_W-1:0] cfg_index = '0;
    logic [rss_pkg::CFG_W-1:0]  cfg_data  = '0;

    rss_in_if  req_ch ();
    rss_out_if res_ch ();

    logic [rss_pkg::CFG_W-1:0] decay_q = rss_pkg::DECAY_RST;
    logic [rss_pkg::CFG_W-1:0] eps_q   = rss_pkg::EPSILON_RST;
    logic [rss_pkg::CFG_W-1:0] gain_q  = rss_pkg::STEP_GAIN_RST;
    logic [rss_pkg::ACC_W-1:0] mean_sq [SLOTS] = '{default: '0};

    grad_req_t grads_pending [$];
    step_res_t steps_due [$];

    logic req_taken    = 1'b0;
    logic result_taken = 1'b0;
    int   send_gap     = 0;
    int   send_calm    = 0;
    int   recv_stall   = 0;
    int   recv_calm    = 0;
    int   hold_left    = 0;
    int   requests_seen = 0;
    int   results_seen  = 0;
    int   clips_seen    = 0;
    int   mismatches    = 0;
    int   quiet_cycles  = 0;
    int   settings_used = 1;

    rmsprop_step_scaler_top #(.DEPTH(SLOTS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .result    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        int          b;
        root = '0;
        for (b = 25; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic step_res_t scaled_step(input grad_req_t r);
        logic        neg;
        logic [16:0] mag;
        logic [63:0] sq;
        logic [63:0] blend;
        logic [63:0] radicand;
        logic [63:0] root;
        logic [63:0] quot;
        step_res_t   res;
        neg = r.grad[rss_pkg::GRAD_W-1];
        mag = neg ? 17'(17'h10000 - {1'b0, r.grad}) : {1'b0, r.grad};
        sq = 64'(mag) * 64'(mag);
        res.clipped = 1'b0;
        blend = (64'(decay_q) * 64'(mean_sq[r.slot]) + (64'd65536 - 64'(decay_q)) * sq) >> 16;
        if (blend > 64'hFFFF_FFFF)
        begin
            blend = 64'hFFFF_FFFF;
            res.clipped = 1'b1;
        end
        mean_sq[r.slot] = blend[rss_pkg::ACC_W-1:0];
        radicand = blend + 64'(eps_q);
        quot = '0;
        if (radicand != 0)
        begin
            root = floor_root(radicand << 16);
            if (root != 0)
                quot = (64'd4096 * 64'(gain_q) * 64'(mag)) / root;
        end
        if (!neg)
        begin
            if (quot > 64'(rss_pkg::DIR_POS_MAX))
            begin
                quot = 64'(rss_pkg::DIR_POS_MAX);
                res.clipped = 1'b1;
            end
            res.direction = quot[rss_pkg::DIR_W-1:0];
        end
        else
        begin
            if (quot > 64'(rss_pkg::DIR_NEG_MAX))
            begin
                quot = 64'(rss_pkg::DIR_NEG_MAX);
                res.clipped = 1'b1;
            end
            res.direction = rss_pkg::DIR_W'(24'h0 - quot[rss_pkg::DIR_W-1:0]);
        end
        return res;
    endfunction

    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            calm = $urandom_range(10, 40);
        return $urandom_range(0, 14);
    endfunction

    function automatic grad_req_t wild_req(input int unsigned hot);
        grad_req_t   r;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            r.grad = rss_pkg::GRAD_W'($urandom);
        else if (pick < 6)
            r.grad = rss_pkg::GRAD_W'($urandom_range(0, 511));
        else if (pick == 6)
        begin
            case ($urandom_range(0, 3))
                0: r.grad = GRAD_MAX;
                1: r.grad = GRAD_MIN;
                2: r.grad = GRAD_NEG1;
                default: r.grad = '0;
            endcase
        end
        else
            r.grad = rss_pkg::GRAD_W'($urandom_range(0, 4095));
        if (pick >= 4 && pick != 6 && $urandom_range(0, 1) == 1)
            r.grad = -r.grad;
        if ($urandom_range(0, 9) < 6)
            r.slot = rss_pkg::SLOT_W'(hot + $urandom_range(0, 3));
        else
            r.slot = rss_pkg::SLOT_W'($urandom);
        return r;
    endfunction

    function automatic void queue_req(input logic [rss_pkg::GRAD_W-1:0] g,
                                      input int unsigned s);
        grad_req_t r;
        r.grad = g;
        r.slot = rss_pkg::SLOT_W'(s);
        grads_pending.push_back(r);
    endfunction

    task automatic write_reg(input logic [rss_pkg::CIDX_W-1:0] idx,
                             input logic [rss_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
    endtask

    task automatic drain_all();
        while (grads_pending.size() != 0 || req_ch.valid || steps_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        grad_req_t r;
        if (rst_n)
        begin
            if (!req_ch.valid || req_taken)
            begin
                if (grads_pending.size() != 0 && send_gap == 0)
                begin
                    r = grads_pending.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.grad  <= r.grad;
                    req_ch.slot  <= r.slot;
                    send_gap = draw_gap(send_calm);
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                recv_stall = draw_gap(recv_calm);
                if (results_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (res_ch.valid && recv_stall > 0)
            begin
                recv_stall--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        grad_req_t r;
        step_res_t want;
        if (rst_n)
        begin
            req_taken    <= req_ch.valid && req_ch.ready;
            result_taken <= res_ch.valid && res_ch.ready;
            if (cfg_we)
            begin
                case (cfg_index)
                    rss_pkg::CFG_DECAY:     decay_q = cfg_data;
                    rss_pkg::CFG_EPSILON:   eps_q   = cfg_data;
                    rss_pkg::CFG_STEP_GAIN: gain_q  = cfg_data;
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready)
            begin
                r.grad = req_ch.grad;
                r.slot = req_ch.slot;
                steps_due.push_back(scaled_step(r));
                requests_seen++;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                results_seen++;
                if (res_ch.clipped === 1'b1)
                    clips_seen++;
                if (steps_due.size() == 0)
                begin
                    $error("result with no request waiting: direction %0d, clipped %0b",
                           res_ch.direction, res_ch.clipped);
                    mismatches++;
                end
                else
                begin
                    want = steps_due.pop_front();
                    if (res_ch.direction !== want.direction)
                    begin
                        $error("direction mismatch: expected %0d, actual %0d",
                               want.direction, res_ch.direction);
                        mismatches++;
                    end
                    if (res_ch.clipped !== want.clipped)
                    begin
                        $error("clipped mismatch: expected %0b, actual %0b",
                               want.clipped, res_ch.clipped);
                        mismatches++;
                    end
                end
            end
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $error("no request or result moved for %0d cycles", quiet_cycles);
                $display("FAIL rmsprop_step_scaler_top");
                $finish;
            end
        end
    end

    initial
    begin
        int                        phase;
        int unsigned               hot;
        logic [rss_pkg::CFG_W-1:0] decay_v;
        logic [rss_pkg::CFG_W-1:0] eps_v;
        logic [rss_pkg::CFG_W-1:0] gain_v;
        req_ch.valid = 1'b0;
        req_ch.grad  = '0;
        req_ch.slot  = '0;
        res_ch.ready = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (phase = 0; phase < PHASES; phase++)
        begin
            if (phase > 0)
            begin
                decay_v = rss_pkg::CFG_W'($urandom);
                eps_v   = rss_pkg::CFG_W'($urandom);
                gain_v  = rss_pkg::CFG_W'($urandom_range(1, 65535));
                case (phase)
                    1: begin decay_v = '0; eps_v = '0; gain_v = '1; end
                    2: begin decay_v = '1; eps_v = '1; gain_v = '1; end
                    3: begin eps_v = '0; gain_v = 16'd1; end
                    4: gain_v = '0;
                    default: ;
                endcase
                write_reg(rss_pkg::CFG_DECAY, decay_v);
                write_reg(rss_pkg::CFG_EPSILON, eps_v);
                write_reg(rss_pkg::CFG_STEP_GAIN, gain_v);
                if (phase == 4)
                    write_reg(CFG_SPARE, rss_pkg::CFG_W'($urandom));
                @(negedge clk);
                cfg_we <= 1'b0;
                settings_used++;
            end
            case (phase)
                0:
                begin
                    queue_req(GRAD_MAX, 0);
                    queue_req(GRAD_MIN, 1023);
                    queue_req('0, 5);
                    queue_req(16'h0001, 1);
                    queue_req(GRAD_NEG1, 2);
                    queue_req(16'h5555, 341);
                    queue_req(16'hAAAA, 682);
                    queue_req(GRAD_MAX, 7);
                    queue_req(GRAD_MAX, 7);
                    queue_req(GRAD_MAX, 7);
                    queue_req('0, 7);
                    queue_req(GRAD_MIN, 7);
                    queue_req(GRAD_MIN, 7);
                    queue_req(16'h0001, 7);
                    queue_req(16'h1000, 8);
                    queue_req(16'hF000, 8);
                    queue_req(16'h0100, 1023);
                    queue_req('0, 1023);
                end
                1:
                begin
                    queue_req('0, 3);
                    queue_req(GRAD_MIN, 3);
                    queue_req('0, 3);
                    queue_req(GRAD_MAX, 3);
                end
                2:
                begin
                    queue_req(GRAD_MIN, 900);
                    queue_req(GRAD_MAX, 901);
                    queue_req(GRAD_NEG1, 902);
                end
                default: ;
            endcase
            hot = $urandom_range(0, SLOTS - 4);
            repeat (RANDOM_PER_PHASE) grads_pending.push_back(wild_req(hot));
            drain_all();
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (steps_due.size() != 0)
        begin
            $error("%0d expected results never arrived", steps_due.size());
            mismatches++;
        end
        $display("Run covered %0d requests under %0d register settings, %0d results clipped.",
                 requests_seen, settings_used, clips_seen);
        if (mismatches == 0)
            $display("PASS rmsprop_step_scaler_top");
        else
            $display("FAIL rmsprop_step_scaler_top");
        $finish;
    end

endmodule
